[design/srs19_pkg.sv]
// ----------------------------------------------------------------------------
// srs19_pkg
// shared constants and helpers for the s19 record encoder
// ----------------------------------------------------------------------------
package srs19_pkg;

    // data bytes per full s1 record and longest s0 header text
    localparam int RECORD_BYTES = 16;
    localparam int HEADER_MAX   = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_HDR_LOW   = 2'd0;
    localparam logic [1:0] CFG_HDR_HIGH  = 2'd1;
    localparam logic [1:0] CFG_HDR_LEN   = 2'd2;
    localparam logic [1:0] CFG_START_ADR = 2'd3;

    // record kinds
    typedef logic [1:0] rec_kind_t;
    localparam rec_kind_t REC_S0 = 2'd0;
    localparam rec_kind_t REC_S1 = 2'd1;
    localparam rec_kind_t REC_S5 = 2'd2;
    localparam rec_kind_t REC_S9 = 2'd3;

    // action codes on the input channel
    localparam logic ACT_DATA   = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    // ascii
    localparam logic [7:0] CHAR_S  = 8'h53;
    localparam logic [7:0] CHAR_NL = 8'h0A;

    // uppercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
    endfunction

    // record type digit after the leading s
    function automatic logic [7:0] type_char(input rec_kind_t kind);
        logic [7:0] c;
        c = 8'h30;
        case (kind)
            REC_S0:  c = 8'h30;
            REC_S1:  c = 8'h31;
            REC_S5:  c = 8'h35;
            REC_S9:  c = 8'h39;
            default: c = 8'h30;
        endcase
        type_char = c;
    endfunction

endpackage

[design/srecord_s19_encoder_top.sv]
// ----------------------------------------------------------------------------
// srecord_s19_encoder_top
// byte stream to motorola s19 text, one ascii character per output transaction
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one transaction per raw data byte (s_action data) or a
//   finish request (s_action finish). m_ channel carries one ascii character
//   per transaction; m_last_of_run marks the final character caused by one
//   input transaction.
//   the first data byte of a file sends an s0 header record. every sixteenth
//   buffered byte sends an s1 record of 43 characters. finish flushes a
//   partial s1, then sends s5 (s1 count) and s9.
// flow:
//   the record sequencer emits one character per cycle unless a low m_ready
//   stalls it. an input transaction that does more than buffer a byte starts a
//   run of characters (s0: 11 + 2 * header bytes, s1: 11 + 2 * data bytes,
//   tail: 22). s_ready is low while the sequencer is emitting.
//   data bytes sit in a 16 x 8 synchronous buffer memory, read one position
//   ahead of the hex digits that need them.
// reset: clears file state and configuration, output channel goes empty.
// stall: a low m_ready freezes the output register and the sequencer; the
//   character shown stays unchanged until taken.
// ----------------------------------------------------------------------------
module srecord_s19_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_data_byte,
    // output channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_last_of_run
);
    import srs19_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_S    = 3'd1;
    localparam logic [2:0] ST_TYPE = 3'd2;
    localparam logic [2:0] ST_HI   = 3'd3;
    localparam logic [2:0] ST_LO   = 3'd4;
    localparam logic [2:0] ST_NL   = 3'd5;

    // configuration registers
    logic [63:0] hdr_low_reg, hdr_high_reg;
    logic [4:0]  hdr_len_reg;
    logic [15:0] start_adr_reg;

    // file state
    logic [4:0]  fill_reg, fill_next;
    logic [15:0] cur_adr_reg, cur_adr_next;
    logic [15:0] rec_cnt_reg, rec_cnt_next;
    logic        hdr_sent_reg, hdr_sent_next;

    // sequencer
    logic [2:0]  state_reg, state_next;
    rec_kind_t   rec_reg, rec_next;
    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic        pend_s1_reg, pend_s1_next;
    logic        pend_tail_reg, pend_tail_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_char_reg, m_char_next;
    logic        m_last_reg, m_last_next;

    // record buffer memory
    logic [7:0]  buf_mem [RECORD_BYTES];
    logic [7:0]  rd_data_reg;
    logic [3:0]  rd_addr;
    logic [3:0]  wr_addr;
    logic        wr_en;

    logic        accept;
    logic        advance;
    logic [4:0]  fill_new;
    logic [4:0]  hdr_len_eff;
    logic [4:0]  rec_len;
    logic [4:0]  last_pos;
    logic [15:0] rec_adr;
    logic [3:0]  data_idx;
    logic [127:0] hdr_bytes;
    logic [7:0]  cur_byte;

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign advance       = (state_reg != ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid       = m_valid_reg;
    assign m_out_char    = m_char_reg;
    assign m_last_of_run = m_last_reg;

    // header length above the limit is taken as the limit
    assign hdr_len_eff = (hdr_len_reg > 5'(HEADER_MAX)) ? 5'(HEADER_MAX) : hdr_len_reg;
    assign hdr_bytes   = {hdr_high_reg, hdr_low_reg};

    // first file byte goes to slot zero
    assign fill_new = (hdr_sent_reg ? fill_reg : 5'd0) + 5'd1;
    assign wr_addr  = hdr_sent_reg ? fill_reg[3:0] : 4'd0;
    assign wr_en    = accept && (s_action == ACT_DATA);

    // per-record length and address field
    always_comb begin
        rec_len = 5'd0;
        rec_adr = 16'h0000;
        case (rec_reg)
            REC_S0: rec_len = hdr_len_eff;
            REC_S1: begin
                rec_len = fill_reg;
                rec_adr = cur_adr_reg;
            end
            REC_S5: rec_adr = rec_cnt_reg;
            default: begin
                rec_len = 5'd0;
                rec_adr = 16'h0000;
            end
        endcase
    end

    assign last_pos = rec_len + 5'd3;
    assign data_idx = 4'(pos_reg - 5'd3);

    // byte being printed: count, address hi, address lo, data..., checksum
    always_comb begin
        if (pos_reg == last_pos) begin
            cur_byte = ~sum_reg;
        end else if (pos_reg == 5'd0) begin
            cur_byte = 8'(last_pos);
        end else if (pos_reg == 5'd1) begin
            cur_byte = rec_adr[15:8];
        end else if (pos_reg == 5'd2) begin
            cur_byte = rec_adr[7:0];
        end else if (rec_reg == REC_S0) begin
            cur_byte = hdr_bytes[{data_idx, 3'b000} +: 8];
        end else begin
            cur_byte = rd_data_reg;
        end
    end

    // read one position ahead so the data byte is ready at its hex digits
    assign rd_addr = 4'(pos_next - 5'd3);

    always_comb begin
        state_next     = state_reg;
        rec_next       = rec_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        pend_s1_next   = pend_s1_reg;
        pend_tail_next = pend_tail_reg;
        fill_next      = fill_reg;
        cur_adr_next   = cur_adr_reg;
        rec_cnt_next   = rec_cnt_reg;
        hdr_sent_next  = hdr_sent_reg;
        m_valid_next   = m_valid_reg;
        m_char_next    = m_char_reg;
        m_last_next    = m_last_reg;

        // output slot taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // new input transaction
        if (accept) begin
            if (s_action == ACT_DATA) begin
                fill_next    = fill_new;
                pend_tail_next = 1'b0;
                pend_s1_next = (fill_new >= 5'(RECORD_BYTES));
                if (!hdr_sent_reg) begin
                    hdr_sent_next = 1'b1;
                    cur_adr_next  = start_adr_reg;
                    rec_cnt_next  = 16'h0000;
                    rec_next      = REC_S0;
                    state_next    = ST_S;
                end else if (fill_new >= 5'(RECORD_BYTES)) begin
                    pend_s1_next = 1'b0;
                    rec_next     = REC_S1;
                    state_next   = ST_S;
                end
            end else begin
                pend_s1_next   = 1'b0;
                pend_tail_next = 1'b1;
                rec_next       = (fill_reg != 5'd0) ? REC_S1 : REC_S5;
                state_next     = ST_S;
            end
        end

        // one character per advance
        if (advance) begin
            m_valid_next = 1'b1;
            m_last_next  = 1'b0;
            unique case (state_reg)
                ST_S: begin
                    m_char_next = CHAR_S;
                    state_next  = ST_TYPE;
                end
                ST_TYPE: begin
                    m_char_next = type_char(rec_reg);
                    pos_next    = 5'd0;
                    sum_next    = 8'h00;
                    state_next  = ST_HI;
                end
                ST_HI: begin
                    m_char_next = hex_char(cur_byte[7:4]);
                    state_next  = ST_LO;
                end
                ST_LO: begin
                    m_char_next = hex_char(cur_byte[3:0]);
                    sum_next    = sum_reg + cur_byte;
                    if (pos_reg == last_pos) begin
                        state_next = ST_NL;
                    end else begin
                        pos_next   = pos_reg + 5'd1;
                        state_next = ST_HI;
                    end
                end
                ST_NL: begin
                    m_char_next = CHAR_NL;
                    state_next  = ST_S;
                    case (rec_reg)
                        REC_S0: begin
                            if (pend_s1_reg) begin
                                pend_s1_next = 1'b0;
                                rec_next     = REC_S1;
                            end else begin
                                state_next  = ST_IDLE;
                                m_last_next = 1'b1;
                            end
                        end
                        REC_S1: begin
                            cur_adr_next = cur_adr_reg + {11'd0, fill_reg};
                            rec_cnt_next = rec_cnt_reg + 16'd1;
                            fill_next    = 5'd0;
                            if (pend_tail_reg) begin
                                rec_next = REC_S5;
                            end else begin
                                state_next  = ST_IDLE;
                                m_last_next = 1'b1;
                            end
                        end
                        REC_S5: rec_next = REC_S9;
                        default: begin
                            // end of file
                            fill_next      = 5'd0;
                            rec_cnt_next   = 16'h0000;
                            hdr_sent_next  = 1'b0;
                            pend_tail_next = 1'b0;
                            state_next     = ST_IDLE;
                            m_last_next    = 1'b1;
                        end
                    endcase
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rec_reg       <= REC_S0;
            pos_reg       <= 5'd0;
            sum_reg       <= 8'h00;
            pend_s1_reg   <= 1'b0;
            pend_tail_reg <= 1'b0;
            fill_reg      <= 5'd0;
            cur_adr_reg   <= 16'h0000;
            rec_cnt_reg   <= 16'h0000;
            hdr_sent_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            hdr_low_reg   <= 64'd0;
            hdr_high_reg  <= 64'd0;
            hdr_len_reg   <= 5'd0;
            start_adr_reg <= 16'h0000;
        end else begin
            state_reg     <= state_next;
            rec_reg       <= rec_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            pend_s1_reg   <= pend_s1_next;
            pend_tail_reg <= pend_tail_next;
            fill_reg      <= fill_next;
            cur_adr_reg   <= cur_adr_next;
            rec_cnt_reg   <= rec_cnt_next;
            hdr_sent_reg  <= hdr_sent_next;
            m_valid_reg   <= m_valid_next;
            // configuration writes
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_HDR_LOW:   hdr_low_reg   <= cfg_wdata;
                    CFG_HDR_HIGH:  hdr_high_reg  <= cfg_wdata;
                    CFG_HDR_LEN:   hdr_len_reg   <= cfg_wdata[4:0];
                    CFG_START_ADR: start_adr_reg <= cfg_wdata[15:0];
                    default:       hdr_len_reg   <= hdr_len_reg;
                endcase
            end
        end
    end

    // output payload needs no reset
    always_ff @(posedge aclk) begin
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    // record buffer: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buf_mem[wr_addr] <= s_data_byte;
        end
        rd_data_reg <= buf_mem[rd_addr];
    end

endmodule

[design/srs19_checker.sv]
// ----------------------------------------------------------------------------
// srs19_checker
// port-level checks for the s19 record encoder
// ----------------------------------------------------------------------------
module srs19_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_action,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_char,
    input logic       m_last_of_run
);
    import srs19_pkg::*;

    // output channel empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) && $stable(m_last_of_run))
        else $error("output changed while stalled");

    // a finish always produces text, so input is blocked next cycle
    a_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action == ACT_FINISH) |=> !s_ready)
        else $error("input ready right after finish");

    // every run of characters ends on a newline
    a_last_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_of_run |-> m_out_char == CHAR_NL)
        else $error("run does not end on newline");

endmodule

bind srecord_s19_encoder_top srs19_checker u_srs19_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_action      (s_action),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_char    (m_out_char),
    .m_last_of_run (m_last_of_run)
);
